>>> design/asbs_pkg.sv
// Shared types, constants, sine table and microprogram of the additive sine bank.
package asbs_pkg;

    localparam int OSC_COUNT_DEF = 4;
    localparam int REG_BANK      = 4;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 32;
    localparam int PHASE_W       = 32;
    localparam int GAIN_W        = 17;
    localparam int SAMPLE_W      = 16;
    localparam int FRAC_W        = 16;
    localparam int ROM_W         = 16;
    localparam int PROD_SHIFT    = 32;
    localparam int V_W           = 34;
    localparam int P_W           = V_W + GAIN_W + 1;

    localparam int REG_STEP_BASE = 0;
    localparam int REG_GAIN_BASE = REG_BANK;

    localparam logic [14:0] QUARTER_SINE [0:64] = '{
        15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
        15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
        15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
        15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
        15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
        15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
        15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
        15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
        15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
        15'd32757, 15'd32767
    };

    typedef logic [2:0] step_t;

    localparam step_t ST_IDLE  = 3'd0;
    localparam step_t ST_LOAD  = 3'd1;
    localparam step_t ST_MULV  = 3'd2;
    localparam step_t ST_MULG  = 3'd3;
    localparam step_t ST_ACCUM = 3'd4;
    localparam step_t ST_EMIT  = 3'd5;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_TICK,
        JMP_LOOP,
        JMP_EMIT
    } jmp_t;

    typedef struct packed {
        logic  in_take;
        logic  acc_clr;
        logic  load;
        logic  mul_v;
        logic  mul_g;
        logic  accum;
        logic  emit;
        jmp_t  jmp;
        step_t target;
    } uctrl_t;

    typedef struct packed {
        logic acc_clr;
        logic load;
        logic mul_v;
        logic mul_g;
        logic accum;
    } dp_ctrl_t;

    // Entry i of the 257-entry sine table, built from the quarter wave.
    function automatic logic signed [ROM_W-1:0] sine_rom(input logic [8:0] i);
        logic [8:0]              t;
        logic                    neg;
        logic signed [ROM_W-1:0] mag;
        begin
            if (i <= 9'd64)
            begin
                t   = i;
                neg = 1'b0;
            end
            else if (i <= 9'd128)
            begin
                t   = 9'd128 - i;
                neg = 1'b0;
            end
            else if (i <= 9'd192)
            begin
                t   = i - 9'd128;
                neg = 1'b1;
            end
            else
            begin
                t   = 9'd256 - i;
                neg = 1'b1;
            end
            mag = $signed({1'b0, QUARTER_SINE[t[6:0]]});
            return neg ? -mag : mag;
        end
    endfunction

    // The microprogram: one control word per step.
    function automatic uctrl_t uprog(input step_t pc);
        uctrl_t w;
        begin
            w = '{in_take: 1'b0, acc_clr: 1'b0, load: 1'b0, mul_v: 1'b0, mul_g: 1'b0,
                  accum: 1'b0, emit: 1'b0, jmp: JMP_NEXT, target: ST_IDLE};
            case (pc)
                ST_IDLE:
                begin
                    w.in_take = 1'b1;
                    w.acc_clr = 1'b1;
                    w.jmp     = JMP_TICK;
                    w.target  = ST_IDLE;
                end
                ST_LOAD:  w.load  = 1'b1;
                ST_MULV:  w.mul_v = 1'b1;
                ST_MULG:  w.mul_g = 1'b1;
                ST_ACCUM:
                begin
                    w.accum  = 1'b1;
                    w.jmp    = JMP_LOOP;
                    w.target = ST_LOAD;
                end
                ST_EMIT:
                begin
                    w.emit   = 1'b1;
                    w.jmp    = JMP_EMIT;
                    w.target = ST_IDLE;
                end
                default:
                begin
                    w.jmp    = JMP_EMIT;
                    w.target = ST_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

>>> design/additive_sine_bank_synth.sv
// Additive sine bank: one sample per tick beat, up to four oscillators summed by a microcoded datapath.
// Each accepted beat with tick high yields one 16-bit sample, the wrapped sum of up to four
// interpolated sine oscillators whose phases then advance by their steps; a beat with tick low
// yields nothing. One shared interpolate, multiply and accumulate datapath walks the oscillators
// under a six-step microprogram, with load, interpolate, gain and accumulate steps per oscillator;
// no new beat is taken until the sample is emitted, which waits for the output. Registers 0 to 3
// are the phase steps and 4 to 7 the gains (65536 is unity); write them only while idle.
module additive_sine_bank_synth
#(
    parameter int OSC_COUNT = asbs_pkg::OSC_COUNT_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 tick,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [asbs_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [asbs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [asbs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import asbs_pkg::*;

    dp_ctrl_t                   dp_ctrl;
    logic                       emit;
    logic                       osc_last;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] acc;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    asbs_useq u_useq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .tick     (tick),
        .out_free (out_free),
        .osc_last (osc_last),
        .in_ready (in_ready),
        .emit     (emit),
        .dp_ctrl  (dp_ctrl)
    );

    asbs_datapath #(.OSC_COUNT(OSC_COUNT)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .dp_ctrl   (dp_ctrl),
        .osc_last  (osc_last),
        .acc       (acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sample_reg <= acc;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("Sample written over one not yet taken.");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && sample_reg == $past(acc)))
        else $error("Finished sum did not reach the output register.");

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_ctrl.load || dp_ctrl.mul_v || dp_ctrl.mul_g || dp_ctrl.accum) |-> !in_ready)
        else $error("Input taken while a sample is in progress.");

endmodule

>>> design/asbs_useq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
module asbs_useq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              tick,
    input  logic              out_free,
    input  logic              osc_last,
    output logic              in_ready,
    output logic              emit,
    output asbs_pkg::dp_ctrl_t dp_ctrl
);
    import asbs_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    uctrl_t ucode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        ucode = uprog(pc_reg);
        case (ucode.jmp)
            JMP_NEXT: pc_next = pc_reg + 3'd1;
            JMP_TICK: pc_next = (in_valid && tick) ? pc_reg + 3'd1 : ucode.target;
            JMP_LOOP: pc_next = osc_last ? pc_reg + 3'd1 : ucode.target;
            JMP_EMIT: pc_next = out_free ? ucode.target : pc_reg;
            default:  pc_next = ST_IDLE;
        endcase
        in_ready        = ucode.in_take;
        emit            = ucode.emit && out_free;
        dp_ctrl.acc_clr = ucode.acc_clr;
        dp_ctrl.load    = ucode.load;
        dp_ctrl.mul_v   = ucode.mul_v;
        dp_ctrl.mul_g   = ucode.mul_g;
        dp_ctrl.accum   = ucode.accum;
    end

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && tick) |=> (pc_reg == ST_LOAD))
        else $error("A tick beat did not start the oscillator loop.");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= ST_EMIT)
        else $error("Step counter left the program.");

    a_loop_back: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_ctrl.accum && !osc_last) |=> (pc_reg == ST_LOAD))
        else $error("Oscillator loop did not return to the load step.");

endmodule

>>> design/asbs_datapath.sv
// Datapath: configuration registers, phase accumulators, interpolation, gain and sum.
module asbs_datapath
#(
    parameter int OSC_COUNT = asbs_pkg::OSC_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [asbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  asbs_pkg::dp_ctrl_t                dp_ctrl,
    output logic                              osc_last,
    output logic signed [asbs_pkg::SAMPLE_W-1:0] acc
);
    import asbs_pkg::*;

    localparam int ACTIVE = (OSC_COUNT < REG_BANK) ? OSC_COUNT : REG_BANK;
    localparam int OSC_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

    logic [PHASE_W-1:0]         step_reg  [ACTIVE];
    logic [GAIN_W-1:0]          gain_reg  [ACTIVE];
    logic [PHASE_W-1:0]         phase_reg [ACTIVE];
    logic [OSC_W-1:0]           osc_reg;
    logic signed [ROM_W-1:0]    base_reg;
    logic signed [ROM_W:0]      diff_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic [GAIN_W-1:0]          gsel_reg;
    logic signed [V_W-1:0]      v_reg;
    logic signed [SAMPLE_W-1:0] term_reg;
    logic signed [SAMPLE_W-1:0] acc_reg;

    logic [PHASE_W-1:0]         ph;
    logic [8:0]                 idx;
    logic signed [ROM_W-1:0]    rom_a;
    logic signed [ROM_W-1:0]    rom_b;
    logic signed [FRAC_W:0]     frac_s;
    logic signed [V_W-1:0]      v_next;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [P_W-1:0]      prod_g;

    always_comb
    begin
        ph     = phase_reg[osc_reg];
        idx    = {1'b0, ph[PHASE_W-1 -: 8]};
        rom_a  = sine_rom(idx);
        rom_b  = sine_rom(idx + 9'd1);
        frac_s = $signed({1'b0, frac_reg});
        // rom[i] * 0xFFFF + (rom[i+1] - rom[i]) * f
        v_next = (V_W'(base_reg) <<< FRAC_W) - V_W'(base_reg) + diff_reg * frac_s;
        gain_s = $signed({1'b0, gsel_reg});
        prod_g = v_reg * gain_s;
        osc_last = (osc_reg == OSC_W'(ACTIVE - 1));
        acc      = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ACTIVE; k++)
            begin
                step_reg[k]  <= '0;
                gain_reg[k]  <= '0;
                phase_reg[k] <= '0;
            end
            osc_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                for (int k = 0; k < ACTIVE; k++)
                begin
                    if (cfg_index == CFG_IDX_W'(REG_STEP_BASE + k))
                    begin
                        step_reg[k] <= cfg_data;
                    end
                    if (cfg_index == CFG_IDX_W'(REG_GAIN_BASE + k))
                    begin
                        gain_reg[k] <= cfg_data[GAIN_W-1:0];
                    end
                end
            end
            if (dp_ctrl.acc_clr)
            begin
                osc_reg <= '0;
                acc_reg <= '0;
            end
            else if (dp_ctrl.accum)
            begin
                acc_reg            <= acc_reg + term_reg;
                phase_reg[osc_reg] <= ph + step_reg[osc_reg];
                osc_reg            <= osc_last ? '0 : osc_reg + OSC_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_ctrl.load)
        begin
            base_reg <= rom_a;
            diff_reg <= (ROM_W + 1)'(rom_b) - (ROM_W + 1)'(rom_a);
            frac_reg <= ph[PHASE_W-9 -: FRAC_W];
            gsel_reg <= gain_reg[osc_reg];
        end
        if (dp_ctrl.mul_v)
        begin
            v_reg <= v_next;
        end
        if (dp_ctrl.mul_g)
        begin
            // Arithmetic shift by 32 is the floor; only the low sample bits are kept.
            term_reg <= prod_g[PROD_SHIFT + SAMPLE_W - 1 -: SAMPLE_W];
        end
    end

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        dp_ctrl.acc_clr |=> (acc_reg == '0 && osc_reg == '0))
        else $error("Sum or oscillator index not cleared.");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_ctrl.accum && osc_last) |=> (osc_reg == '0))
        else $error("Oscillator index did not wrap after the last oscillator.");

    a_osc_range: assert property (@(posedge clk) disable iff (!rst_n)
        osc_reg <= OSC_W'(ACTIVE - 1))
        else $error("Oscillator index out of range.");

endmodule
